[sv/xcfp_pkg.sv]
// Package for the XOR-checked frame parser: phase codes, framing constants
// and the step bundle passed from the input stage to the parse core.
// No dependencies.
`timescale 1ns / 1ps

package xcfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;

    localparam logic [BYTE_W-1:0] CHECK_SEED = 8'hFF;
    localparam logic [BYTE_W-1:0] START_CODE = 8'hA0;
    localparam logic [BYTE_W-1:0] START_MASK = 8'hF0;
    localparam int unsigned       VAR_BIT    = 0;

    // Fixed header/check overhead subtracted from the buffer size
    localparam logic [WORD_W-1:0] BUF_OVERHEAD  = 32'd10;
    localparam logic [WORD_W-1:0] BUF_SIZE_RST  = 32'd1024;
    localparam logic [WORD_W-1:0] HDR_CHECK_POS = 32'd6;

    typedef enum logic [2:0] {
        PH_WAIT     = 3'd0,
        PH_HEADER   = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_COMPLETE = 3'd3,
        PH_NOSTART  = 3'd4,
        PH_CHKERR   = 3'd5,
        PH_TOOLARGE = 3'd6
    } t_phase;

    typedef struct packed {
        logic              go;
        logic [BYTE_W-1:0] data;
    } t_step;

endpackage

[sv/xcfp_core.sv]
// Parse core: phase/position/check state, header fields and the payload
// result register, all updated in one step per byte. Uses xcfp_pkg.
`timescale 1ns / 1ps

module xcfp_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  xcfp_pkg::t_step              i_step,
    input  logic [xcfp_pkg::WORD_W-1:0]  i_limit,
    output logic [2:0]                   o_status,
    output logic                         o_data_valid,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_data_byte,
    output logic [xcfp_pkg::WORD_W-1:0]  o_data_index,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_msg_address,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_msg_command,
    output logic [xcfp_pkg::WORD_W-1:0]  o_msg_length
);

    xcfp_pkg::t_phase            r_phase, n_phase;
    logic [xcfp_pkg::WORD_W-1:0] r_pos, n_pos;
    logic [xcfp_pkg::BYTE_W-1:0] r_check, n_check;
    logic [xcfp_pkg::BYTE_W-1:0] r_addr, n_addr;
    logic [xcfp_pkg::BYTE_W-1:0] r_cmd, n_cmd;
    logic [xcfp_pkg::WORD_W-1:0] r_len, n_len;
    logic                        r_dv, n_dv;
    logic [xcfp_pkg::BYTE_W-1:0] r_db, n_db;
    logic [xcfp_pkg::WORD_W-1:0] r_di, n_di;

    logic [xcfp_pkg::BYTE_W-1:0] b;

    assign b = i_step.data;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_check = r_check;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_dv    = 1'b0;
        n_db    = '0;
        n_di    = '0;
        case (r_phase)
            xcfp_pkg::PH_HEADER: begin
                if (r_pos >= xcfp_pkg::HDR_CHECK_POS) begin
                    if (b != r_check) begin
                        n_phase = xcfp_pkg::PH_CHKERR;
                    end else if (r_len > i_limit) begin
                        n_phase = xcfp_pkg::PH_TOOLARGE;
                    end else if (r_len == '0) begin
                        n_phase = xcfp_pkg::PH_COMPLETE;
                    end else begin
                        n_pos   = '0;
                        n_check = xcfp_pkg::CHECK_SEED;
                        n_phase = xcfp_pkg::PH_PAYLOAD;
                    end
                end else begin
                    case (r_pos[2:0])
                        3'd0:    n_addr = b;
                        3'd1:    n_cmd  = b;
                        3'd2:    n_len  = {{(xcfp_pkg::WORD_W-xcfp_pkg::BYTE_W){1'b0}}, b};
                        default: n_len  = {r_len[xcfp_pkg::WORD_W-xcfp_pkg::BYTE_W-1:0], b};
                    endcase
                    n_check = r_check ^ b;
                    n_pos   = r_pos + 32'd1;
                end
            end
            xcfp_pkg::PH_PAYLOAD: begin
                if (r_pos >= r_len) begin
                    n_phase = (b != r_check) ? xcfp_pkg::PH_CHKERR
                                             : xcfp_pkg::PH_COMPLETE;
                end else begin
                    n_dv    = 1'b1;
                    n_db    = b;
                    n_di    = r_pos;
                    n_check = r_check ^ b;
                    n_pos   = r_pos + 32'd1;
                end
            end
            default: begin
                // wait, or any terminal status: byte is a start candidate
                n_check = xcfp_pkg::CHECK_SEED ^ b;
                n_pos   = '0;
                if ((b & xcfp_pkg::START_MASK) != xcfp_pkg::START_CODE) begin
                    n_phase = xcfp_pkg::PH_NOSTART;
                end else if (b[xcfp_pkg::VAR_BIT]) begin
                    n_phase = xcfp_pkg::PH_HEADER;
                end else begin
                    n_phase = xcfp_pkg::PH_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcfp_pkg::PH_WAIT;
            r_pos   <= '0;
            r_check <= xcfp_pkg::CHECK_SEED;
            r_addr  <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_dv    <= 1'b0;
        end else if (i_step.go) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_check <= n_check;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.go) begin
            r_db <= n_db;
            r_di <= n_di;
        end
    end

    assign o_status      = r_phase;
    assign o_data_valid  = r_dv;
    assign o_data_byte   = r_db;
    assign o_data_index  = r_di;
    assign o_msg_address = r_addr;
    assign o_msg_command = r_cmd;
    assign o_msg_length  = r_len;

endmodule

[sv/xor_checked_frame_parser_unit.sv]
// XOR-checked frame parser, top level. An input byte, once transferred, passes
// through the input register, then the parse core result register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset (synchronous, active low): parser waits for a start byte, check
// seed 0xFF, header fields zero, buffer size 1024. Uses xcfp_pkg, xcfp_core.
`timescale 1ns / 1ps

module xor_checked_frame_parser_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [xcfp_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [xcfp_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic                         o_data_valid,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_data_byte,
    output logic [xcfp_pkg::WORD_W-1:0]  o_data_index,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_msg_address,
    output logic [xcfp_pkg::BYTE_W-1:0]  o_msg_command,
    output logic [xcfp_pkg::WORD_W-1:0]  o_msg_length
);

    logic                        r_in_valid;
    logic [xcfp_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_out_valid;
    logic [xcfp_pkg::WORD_W-1:0] r_limit;
    logic                        advance;
    logic                        in_xfer;
    xcfp_pkg::t_step             step;

    // Length limit kept pre-subtracted (mod 2^32) so the header check
    // needs only a compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= xcfp_pkg::BUF_SIZE_RST - xcfp_pkg::BUF_OVERHEAD;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data - xcfp_pkg::BUF_OVERHEAD;
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign step.go   = advance;
    assign step.data = r_in_byte;

    xcfp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_limit       (r_limit),
        .o_status      (o_status),
        .o_data_valid  (o_data_valid),
        .o_data_byte   (o_data_byte),
        .o_data_index  (o_data_index),
        .o_msg_address (o_msg_address),
        .o_msg_command (o_msg_command),
        .o_msg_length  (o_msg_length)
    );

    assign o_out_valid = r_out_valid;

endmodule
